// ----- design/nsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_pkg
// shared types, character codes and helpers of the nmea sentence checker
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int NAME_NUM = 4;
  localparam int NAME_LEN = 5;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);

  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] MIN_LIMIT = 8'd8;
  localparam logic [7:0] LIMIT_RST = 8'd120;

  // GNRMC, GPGSV, GNGGA, GNVTG without the leading dollar sign
  localparam logic [7:0] NAMES [NAME_NUM][NAME_LEN] = '{
    '{8'h47, 8'h4e, 8'h52, 8'h4d, 8'h43},
    '{8'h47, 8'h50, 8'h47, 8'h53, 8'h56},
    '{8'h47, 8'h4e, 8'h47, 8'h47, 8'h41},
    '{8'h47, 8'h4e, 8'h56, 8'h54, 8'h47}
  };

  typedef enum logic [1:0] {
    ST_GOOD = 2'd0,
    ST_BAD  = 2'd1,
    ST_OVER = 2'd2
  } status_t;

  localparam logic [2:0] TYPE_OTHER = 3'd4;

  typedef struct packed {
    logic [7:0]                          data;
    logic                                is_dollar;
    logic                                is_lf;
    logic [NAME_LEN-1:0][NAME_NUM-1:0]   hit;
  } cls_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] stype;
    logic [7:0] length;
    logic [7:0] csum;
  } res_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h41 + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic [2:0] type_code(input logic [NAME_NUM-1:0] flags);
    logic [2:0] r;
    r = TYPE_OTHER;
    for (int k = NAME_NUM - 1; k >= 0; k--) begin
      if (flags[k]) r = 3'(k);
    end
    return r;
  endfunction

endpackage

// ----- design/nmea_sentence_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// nmea 0183 sentence framing, checksum and talker/type check
// ----------------------------------------------------------------------------
// Takes one received byte per cycle through push/full and reports one item
// per finished sentence through empty/pop: status (good, bad trailer or
// checksum, overlength), sentence type, length and computed checksum. A byte
// is taken every cycle while the result side keeps up; the first result of a
// sentence is carried through the input register, the four-entry byte queue
// and the two-entry result buffer after its closing line feed is taken.
// max_sentence_length is written through cfg_valid/cfg_ready/cfg_data,
// which is always ready; values below 8 act as 8, and reset sets 120.
module nmea_sentence_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_in,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status,
  output logic [2:0] sentence_type,
  output logic [7:0] sentence_length,
  output logic [7:0] computed_checksum,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import nsc_pkg::*;

  logic       max_len;
  logic [7:0] max_sentence_length;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  cls_t       q_wr_item;
  cls_t       q_rd_item;
  res_t       res;

  assign cfg_ready = 1'b1;
  assign max_len   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sentence_length <= LIMIT_RST;
    end else if (max_len) begin
      max_sentence_length <= cfg_data;
    end
  end

  nsc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .byte_in (byte_in),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_item  (q_wr_item)
  );

  nsc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  nsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .max_len (max_sentence_length),
    .q_empty (q_empty),
    .q_item  (q_rd_item),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign status            = res.status;
  assign sentence_type     = res.stype;
  assign sentence_length   = res.length;
  assign computed_checksum = res.csum;

endmodule

// ----- design/nsc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_front
// input register that takes bytes and tags delimiters and name matches
// ----------------------------------------------------------------------------
module nsc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    byte_in,
  output logic          q_push,
  input  logic          q_full,
  output nsc_pkg::cls_t q_item
);
  import nsc_pkg::*;

  logic  valid;
  logic  valid_next;
  cls_t  item;
  logic  take;

  assign full   = valid && q_full;
  assign take   = push && !full;
  assign q_push = valid && !q_full;
  assign q_item = item;

  always_comb begin
    valid_next = valid;
    if (q_push) valid_next = 1'b0;
    if (take)   valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.data      <= byte_in;
      item.is_dollar <= (byte_in == CH_DOLLAR);
      item.is_lf     <= (byte_in == CH_LF);
      for (int p = 0; p < NAME_LEN; p++) begin
        for (int k = 0; k < NAME_NUM; k++) begin
          item.hit[p][k] <= (byte_in == NAMES[k][p]);
        end
      end
    end
  end

endmodule

// ----- design/nsc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_queue
// short queue of tagged bytes between front and back
// ----------------------------------------------------------------------------
module nsc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  nsc_pkg::cls_t wr_item,
  output logic          full,
  input  logic          rd_en,
  output nsc_pkg::cls_t rd_item,
  output logic          empty
);
  import nsc_pkg::*;

  cls_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_item;
  end

endmodule

// ----- design/nsc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_back
// sentence tracker: checksum, trailer check, type match and result buffer
// ----------------------------------------------------------------------------
module nsc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    max_len,
  input  logic          q_empty,
  input  nsc_pkg::cls_t q_item,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output nsc_pkg::res_t res
);
  import nsc_pkg::*;

  logic                in_sentence;
  logic [31:0]         recent;
  logic [7:0]          run_xor;
  logic [7:0]          count;
  logic [NAME_NUM-1:0] flags;

  logic                in_sentence_next;
  logic [31:0]         recent_next;
  logic [7:0]          run_xor_next;
  logic [7:0]          count_next;
  logic [NAME_NUM-1:0] flags_next;

  res_t                res_mem [2];
  logic                res_wr;
  logic                res_rd;
  logic [1:0]          res_count;
  logic                res_wp;
  logic                res_rp;

  logic                emit;
  res_t                emit_res;
  logic [7:0]          limit;
  logic                good;

  assign q_pop = !q_empty && (res_count != 2'd2);
  assign limit = (max_len < MIN_LIMIT) ? MIN_LIMIT : max_len;

  always_comb begin
    in_sentence_next = in_sentence;
    recent_next      = recent;
    run_xor_next     = run_xor;
    count_next       = count;
    flags_next       = flags;
    emit             = 1'b0;
    emit_res         = '0;
    good             = 1'b0;
    if (q_item.is_dollar) begin
      in_sentence_next = 1'b1;
      recent_next      = '0;
      run_xor_next     = '0;
      count_next       = 8'd1;
      flags_next       = '1;
    end else if (in_sentence) begin
      for (int p = 0; p < NAME_LEN; p++) begin
        if (count == 8'(p + 1)) flags_next = flags & q_item.hit[p];
      end
      count_next = count + 8'd1;
      if (q_item.is_lf && recent[7:0] == CH_CR) begin
        good = (recent[31:24] == CH_STAR) &&
               (recent[23:16] == hex_char(run_xor[7:4])) &&
               (recent[15:8] == hex_char(run_xor[3:0]));
        emit             = 1'b1;
        emit_res.status  = good ? ST_GOOD : ST_BAD;
        emit_res.stype   = type_code(flags_next);
        emit_res.length  = count_next;
        emit_res.csum    = run_xor;
        in_sentence_next = 1'b0;
      end else begin
        run_xor_next = run_xor ^ recent[31:24];
        recent_next  = {recent[23:0], q_item.data};
        if (count_next >= limit) begin
          emit             = 1'b1;
          emit_res.status  = ST_OVER;
          emit_res.stype   = type_code(flags_next);
          emit_res.length  = count_next;
          emit_res.csum    = run_xor_next ^ recent_next[31:24] ^ recent_next[23:16]
                             ^ recent_next[15:8] ^ recent_next[7:0];
          in_sentence_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence <= 1'b0;
      recent      <= '0;
      run_xor     <= '0;
      count       <= '0;
      flags       <= '1;
    end else if (q_pop) begin
      in_sentence <= in_sentence_next;
      recent      <= recent_next;
      run_xor     <= run_xor_next;
      count       <= count_next;
      flags       <= flags_next;
    end
  end

  // two-entry result buffer
  assign res_wr = q_pop && emit;
  assign res_rd = pop && !empty;
  assign empty  = (res_count == 2'd0);
  assign res    = res_mem[res_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= '0;
      res_wp    <= 1'b0;
      res_rp    <= 1'b0;
    end else begin
      if (res_wr) res_wp <= !res_wp;
      if (res_rd) res_rp <= !res_rp;
      if (res_wr && !res_rd) res_count <= res_count + 2'd1;
      else if (res_rd && !res_wr) res_count <= res_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) res_mem[res_wp] <= emit_res;
  end

endmodule
